/* rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

/* rtl/hns_pkg.sv */
package hns_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] SPEED_RESET = 16'd2560;
  localparam logic [20:0] ONE_Q20     = 21'h100000;

  // dot <= -0.999 in Q2.28, integer form
  localparam logic signed [32:0] DOT_LIMIT   = -33'sd268167021;
  // len2 * 1e6 < 2^40
  localparam logic [43:0]        DEGEN_LIMIT = 44'd1099512;
  localparam logic [15:0]        Q_MAX       = 16'd16384;

  typedef enum logic [1:0] {
    OUTCOME_EASED      = 2'd0,
    OUTCOME_NO_SMOOTH  = 2'd1,
    OUTCOME_OPPOSITE   = 2'd2,
    OUTCOME_DEGENERATE = 2'd3
  } outcome_e;

  typedef struct packed {
    logic signed [15:0] tc;
    logic signed [15:0] ts;
    logic signed [22:0] ec;
    logic signed [22:0] es;
    outcome_e           outcome;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // round(x / 2^14), ties away from zero
  function automatic logic signed [22:0] round_q14(input logic signed [39:0] x);
    logic [39:0] mag;
    logic [39:0] r;
    logic [22:0] rs;
    mag = x[39] ? 40'(-x) : 40'(x);
    r   = (mag + 40'd8192) >> 14;
    rs  = r[22:0];
    return x[39] ? signed'(23'(-rs)) : signed'(rs);
  endfunction

endpackage

/* rtl/hns_front.sv */
module hns_front import hns_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        speed_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] current_cos_i,
  input  logic signed [15:0] current_sin_i,
  input  logic signed [15:0] target_cos_i,
  input  logic signed [15:0] target_sin_i,
  input  logic [15:0]        frame_time_i,
  input  q_status_t          q_status_i,
  output logic               push_o,
  output item_t              item_o
);

  logic fe;
  logic f1_v_q, f2_v_q, f3_v_q;

  logic signed [15:0] f1_cc_q, f1_cs_q, f1_tc_q, f1_ts_q;
  logic [20:0]        f1_f_q;
  logic               f1_ns_q;

  logic signed [15:0] f2_cc_q, f2_cs_q, f2_tc_q, f2_ts_q;
  logic signed [32:0] f2_dot_q;
  logic signed [38:0] f2_pc_q, f2_ps_q;
  logic               f2_ns_q;

  item_t              f3_q;

  logic [31:0]        prod;
  logic [20:0]        f_d;
  logic signed [16:0] dc, ds;
  logic signed [38:0] pc_d, ps_d;
  logic signed [32:0] dot_d;
  item_t              f3_d;

  assign fe         = !f3_v_q || !q_status_i.full;
  assign in_ready_o = fe;
  assign push_o     = f3_v_q && !q_status_i.full;
  assign item_o     = f3_q;

  always_comb begin
    prod = 32'(speed_i) * 32'(frame_time_i);
    f_d  = (prod > 32'(ONE_Q20)) ? ONE_Q20 : prod[20:0];
  end

  always_comb begin
    dc    = 17'(f1_tc_q) - 17'(f1_cc_q);
    ds    = 17'(f1_ts_q) - 17'(f1_cs_q);
    pc_d  = 39'(dc) * 39'(signed'({1'b0, f1_f_q}));
    ps_d  = 39'(ds) * 39'(signed'({1'b0, f1_f_q}));
    dot_d = 33'(f1_cc_q) * 33'(f1_tc_q) + 33'(f1_cs_q) * 33'(f1_ts_q);
  end

  always_comb begin
    f3_d.tc = f2_tc_q;
    f3_d.ts = f2_ts_q;
    f3_d.ec = round_q14((40'(f2_cc_q) <<< 20) + 40'(f2_pc_q));
    f3_d.es = round_q14((40'(f2_cs_q) <<< 20) + 40'(f2_ps_q));
    if (f2_ns_q) begin
      f3_d.outcome = OUTCOME_NO_SMOOTH;
    end else if (f2_dot_q <= DOT_LIMIT) begin
      f3_d.outcome = OUTCOME_OPPOSITE;
    end else begin
      f3_d.outcome = OUTCOME_EASED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (fe) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      f1_cc_q  <= current_cos_i;
      f1_cs_q  <= current_sin_i;
      f1_tc_q  <= target_cos_i;
      f1_ts_q  <= target_sin_i;
      f1_f_q   <= f_d;
      f1_ns_q  <= (speed_i == 16'd0) || (frame_time_i == 16'd0);
      f2_cc_q  <= f1_cc_q;
      f2_cs_q  <= f1_cs_q;
      f2_tc_q  <= f1_tc_q;
      f2_ts_q  <= f1_ts_q;
      f2_dot_q <= dot_d;
      f2_pc_q  <= pc_d;
      f2_ps_q  <= ps_d;
      f2_ns_q  <= f1_ns_q;
      f3_q     <= f3_d;
    end
  end

endmodule

/* rtl/hns_queue.sv */
module hns_queue import hns_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  input  logic      pop_i,
  output item_t     item_o,
  output q_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign item_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

/* rtl/hns_back.sv */
module hns_back import hns_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  q_status_t          q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] result_cos_o,
  output logic signed [15:0] result_sin_o,
  output logic [1:0]         outcome_o
);

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sq_t;

  typedef struct packed {
    logic [47:0] rc;
    logic [47:0] rs;
    logic [15:0] qc;
    logic [15:0] qs;
    logic [31:0] root;
  } dv_t;

  // One step of the bit-pair square root, bit = 4^(31-k)
  function automatic sq_t sq_step(input sq_t s, input logic [63:0] bitv);
    sq_t         n;
    logic [63:0] trial;
    trial = s.res + bitv;
    n     = s;
    if (s.rem >= trial) begin
      n.rem = s.rem - trial;
      n.res = (s.res >> 1) + bitv;
    end else begin
      n.res = s.res >> 1;
    end
    return n;
  endfunction

  // Restoring division step for quotient bit i, both components
  function automatic dv_t dv_step(input dv_t d, input int i);
    dv_t         n;
    logic [47:0] sh;
    sh = 48'(d.root) << i;
    n  = d;
    if (d.rc >= sh) begin
      n.rc    = d.rc - sh;
      n.qc[i] = 1'b1;
    end
    if (d.rs >= sh) begin
      n.rs    = d.rs - sh;
      n.qs[i] = 1'b1;
    end
    return n;
  endfunction

  logic        be;
  logic        b0_v_q, b1_v_q, out_v_q;
  logic [32:0] sq_v_q;
  logic [16:0] dv_v_q;

  item_t       b0_q, b1_q;
  logic [43:0] len2_q;
  item_t       sq_pl_q [33];
  sq_t         sq_q    [33];
  item_t       dv_pl_q [17];
  dv_t         dv_q    [17];

  logic signed [15:0] res_c_q, res_s_q;
  outcome_e           outc_q;

  logic signed [45:0] sqc, sqs;
  logic [43:0]        len2_d;
  item_t              sq0_pl_d;
  dv_t                dv0_d;
  logic [22:0]        mag_c, mag_s;
  logic [15:0]        mc, ms;
  logic signed [15:0] rc_d, rs_d;

  assign be           = !out_v_q || out_ready_i;
  assign pop_o        = be && !q_status_i.empty;
  assign out_valid_o  = out_v_q;
  assign result_cos_o = res_c_q;
  assign result_sin_o = res_s_q;
  assign outcome_o    = outc_q;

  always_comb begin
    sqc    = 46'(b0_q.ec) * 46'(b0_q.ec);
    sqs    = 46'(b0_q.es) * 46'(b0_q.es);
    len2_d = 44'(sqc) + 44'(sqs);
  end

  always_comb begin
    sq0_pl_d = b1_q;
    if (b1_q.outcome == OUTCOME_EASED && len2_q < DEGEN_LIMIT) begin
      sq0_pl_d.outcome = OUTCOME_DEGENERATE;
    end
  end

  always_comb begin
    mag_c      = sq_pl_q[32].ec[22] ? 23'(-sq_pl_q[32].ec) : 23'(sq_pl_q[32].ec);
    mag_s      = sq_pl_q[32].es[22] ? 23'(-sq_pl_q[32].es) : 23'(sq_pl_q[32].es);
    dv0_d.root = sq_q[32].res[31:0];
    dv0_d.rc   = (48'(mag_c) << 24) + 48'(sq_q[32].res[31:1]);
    dv0_d.rs   = (48'(mag_s) << 24) + 48'(sq_q[32].res[31:1]);
    dv0_d.qc   = '0;
    dv0_d.qs   = '0;
  end

  always_comb begin
    mc = (dv_q[16].qc > Q_MAX) ? Q_MAX : dv_q[16].qc;
    ms = (dv_q[16].qs > Q_MAX) ? Q_MAX : dv_q[16].qs;
    if (dv_pl_q[16].outcome != OUTCOME_EASED) begin
      rc_d = dv_pl_q[16].tc;
      rs_d = dv_pl_q[16].ts;
    end else begin
      rc_d = dv_pl_q[16].ec[22] ? signed'(16'(-mc)) : signed'(mc);
      rs_d = dv_pl_q[16].es[22] ? signed'(16'(-ms)) : signed'(ms);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q  <= 1'b0;
      b1_v_q  <= 1'b0;
      sq_v_q  <= '0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (be) begin
      b0_v_q  <= !q_status_i.empty;
      b1_v_q  <= b0_v_q;
      sq_v_q  <= {sq_v_q[31:0], b1_v_q};
      dv_v_q  <= {dv_v_q[15:0], sq_v_q[32]};
      out_v_q <= dv_v_q[16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      b0_q       <= item_i;
      b1_q       <= b0_q;
      len2_q     <= len2_d;
      sq_pl_q[0] <= sq0_pl_d;
      sq_q[0]    <= '{rem: {len2_q, 20'd0}, res: 64'd0};
      for (int k = 0; k < 32; k++) begin
        sq_pl_q[k+1] <= sq_pl_q[k];
        sq_q[k+1]    <= sq_step(sq_q[k], 64'd1 << (62 - 2 * k));
      end
      dv_pl_q[0] <= sq_pl_q[32];
      dv_q[0]    <= dv0_d;
      for (int k = 0; k < 16; k++) begin
        dv_pl_q[k+1] <= dv_pl_q[k];
        dv_q[k+1]    <= dv_step(dv_q[k], 15 - k);
      end
      res_c_q <= rc_d;
      res_s_q <= rs_d;
      outc_q  <= dv_pl_q[16].outcome;
    end
  end

endmodule

/* rtl/heading_nlerp_smoother.sv */
// Channel  Dir  Handshake                  Payload
// cfg      in   cfg_valid_i / cfg_ready_o  approach_speed_i
// in       in   in_valid_i / in_ready_o    current_cos/sin_i, target_cos/sin_i, frame_time_i
// out      out  out_valid_o / out_ready_i  result_cos/sin_o, outcome_o
//
// One item per cycle while the queue is not full and out_ready_i is not low; the path, in order:
// 3 front stages, queue, 2 square stages, 33 square-root stages, 17 divide stages, output.
// The square-root step chain and the 16-step divider set the latency, not the rate.
// Reset clears all valid bits and the queue and loads approach_speed to 10.0.
// The front stalls only while the queue is full; the back stalls on out_ready_i.
`include "assert_macros.svh"

module heading_nlerp_smoother import hns_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        approach_speed_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] current_cos_i,
  input  logic signed [15:0] current_sin_i,
  input  logic signed [15:0] target_cos_i,
  input  logic signed [15:0] target_sin_i,
  input  logic [15:0]        frame_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] result_cos_o,
  output logic signed [15:0] result_sin_o,
  output logic [1:0]         outcome_o
);

  logic [15:0] speed_q;
  logic        push, pop;
  item_t       front_item, head_item;
  q_status_t   q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RESET;
    end else if (cfg_valid_i) begin
      speed_q <= approach_speed_i;
    end
  end

  hns_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .speed_i       (speed_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .current_cos_i (current_cos_i),
    .current_sin_i (current_sin_i),
    .target_cos_i  (target_cos_i),
    .target_sin_i  (target_sin_i),
    .frame_time_i  (frame_time_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .item_o        (front_item)
  );

  hns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  hns_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_cos_o (result_cos_o),
    .result_sin_o (result_sin_o),
    .outcome_o    (outcome_o)
  );

  `ASSERT_AT(a_stall_needs_full, clk_i, rst_ni, !in_ready_o |-> q_status.full)
  `ASSERT_AT(a_eased_range, clk_i, rst_ni, (out_valid_o && outcome_o == OUTCOME_EASED) |-> (result_cos_o <= 16'sd16384 && result_cos_o >= -16'sd16384 && result_sin_o <= 16'sd16384 && result_sin_o >= -16'sd16384))
  `ASSERT_AT(a_eased_unit, clk_i, rst_ni, (out_valid_o && outcome_o == OUTCOME_EASED) |-> (result_cos_o >= 16'sd8192 || result_cos_o <= -16'sd8192 || result_sin_o >= 16'sd8192 || result_sin_o <= -16'sd8192))

endmodule
